### hdl/apdc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apdc_pkg: shared definitions for the addressed packet deframer
// Frame phases, event codes, operation codes, register map and the
// byte-wide CRC-16/XMODEM update.
// ----------------------------------------------------------------------------
package apdc_pkg;

    // Frame parser phases, one-hot.
    typedef enum logic [6:0] {
        PH_NOISE    = 7'b0000001,
        PH_PREAMBLE = 7'b0000010,
        PH_ADDRESS  = 7'b0000100,
        PH_SIZE     = 7'b0001000,
        PH_DATA     = 7'b0010000,
        PH_CRC1     = 7'b0100000,
        PH_CRC2     = 7'b1000000
    } t_phase;

    // Packet events reported with every received byte.
    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_COMMIT   = 2'd1,
        EV_CRC_FAIL = 2'd2,
        EV_DROP     = 2'd3
    } t_event;

    // Operation codes carried by each input word.
    localparam logic OP_RX  = 1'b0;
    localparam logic OP_POP = 1'b1;

    // Register map: word index taken from paddr[3:2].
    localparam logic [1:0] REG_OWN_ADDR = 2'd0;

    localparam logic [7:0]  PREAMBLE_BYTE = 8'h00;
    localparam logic [7:0]  SYNC_BYTE     = 8'h55;
    localparam logic [7:0]  BROADCAST     = 8'h00;
    localparam logic [7:0]  SIZE_MASK     = 8'h0F;
    localparam logic [15:0] CRC_POLY      = 16'h1021;
    localparam logic [15:0] CRC_INIT      = 16'h0000;
    localparam logic [15:0] CRC_RESET     = 16'hFFFF;

    // One byte of CRC-16/XMODEM, MSB first, eight shift steps.
    function automatic logic [15:0] crc16_step(input logic [15:0] crc,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

### hdl/apdc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apdc_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module apdc_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### hdl/addressed_packet_deframer_crc.sv
`default_nettype none
// ----------------------------------------------------------------------------
// addressed_packet_deframer_crc: serial packet deframer with CRC commit FIFO
// Finds addressed packets in a byte stream, checks their CRC-16/XMODEM and
// makes the payload of good packets available to pop requests.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (i_valid / o_ready) carries one word per handshake: i_op
//   selects between feeding i_rx_byte to the frame parser and popping one
//   committed payload byte. Every accepted word produces exactly one result
//   word on the output channel (o_valid / i_ready): o_read_valid and
//   o_read_data for pops, o_packet_event for received bytes.
//   The result of a word is registered and shown in the cycle after the word
//   is accepted. Throughput is one word per cycle while results are taken;
//   the whole parse step, including the unrolled eight-step CRC update, sits
//   between the state registers and the result register, and the payload RAM
//   is read at the accept edge so its registered output lines up with the result.
//   When the receiver stalls, the result register holds and o_ready drops
//   until the result is taken; a new word may be accepted in the same cycle
//   the held result leaves.
//   Reset (i_rst_n low at a clock edge) returns the parser to the noise
//   phase, empties the FIFO and clears own_address. The payload RAM is not
//   cleared; only committed entries are ever read. The own_address register
//   sits at APB byte address 0 and should only be written while idle.
// ----------------------------------------------------------------------------
module addressed_packet_deframer_crc import apdc_pkg::*; #(
    parameter int FIFO_DEPTH = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input word channel
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_op,
    input  wire logic [7:0]  i_rx_byte,
    // Result word channel
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_read_valid,
    output logic [7:0]       o_read_data,
    output logic [1:0]       o_packet_event,
    // APB-style configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(FIFO_DEPTH - 1);

    // Circular pointer advance; wraps after the last slot even when the
    // depth is not a power of two.
    function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + AW'(1);
    endfunction

    // Parser and FIFO state.
    t_phase        r_phase,      n_phase;
    logic [4:0]    r_bytes_left, n_bytes_left;
    logic [15:0]   r_crc,        n_crc;
    logic [AW-1:0] r_rd_ptr,     n_rd_ptr;
    logic [AW-1:0] r_cm_ptr,     n_cm_ptr;
    logic [AW-1:0] r_tn_ptr,     n_tn_ptr;
    logic [7:0]    r_own_addr;

    // Result register.
    logic          r_out_valid,  n_out_valid;
    logic          r_rd_valid,   n_rd_valid;
    t_event        r_event,      n_event;

    logic          accept;
    logic          cfg_write;
    logic [15:0]   crc_next;
    logic          ram_we;
    logic          ram_re;
    logic [7:0]    ram_rdata;

    // The result register is a one-deep output stage: a word is taken
    // whenever it is empty or its content is being taken in this cycle.
    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    assign crc_next = crc16_step(r_crc, i_rx_byte);

    always_comb begin
        n_phase      = r_phase;
        n_bytes_left = r_bytes_left;
        n_crc        = r_crc;
        n_rd_ptr     = r_rd_ptr;
        n_cm_ptr     = r_cm_ptr;
        n_tn_ptr     = r_tn_ptr;
        n_rd_valid   = r_rd_valid;
        n_event      = r_event;
        ram_we       = 1'b0;
        ram_re       = 1'b0;

        if (accept) begin
            n_rd_valid = 1'b0;
            n_event    = EV_NONE;
            if (i_op == OP_POP) begin
                // Only committed bytes are visible; an empty FIFO answers
                // with an invalid, zero byte.
                if (r_rd_ptr != r_cm_ptr) begin
                    ram_re     = 1'b1;
                    n_rd_valid = 1'b1;
                    n_rd_ptr   = ptr_next(r_rd_ptr);
                end
            end else begin
                case (r_phase)
                    PH_NOISE: begin
                        if (i_rx_byte == PREAMBLE_BYTE) begin
                            n_phase = PH_PREAMBLE;
                        end
                    end
                    PH_PREAMBLE: begin
                        if (i_rx_byte == SYNC_BYTE) begin
                            n_phase = PH_ADDRESS;
                        end else if (i_rx_byte != PREAMBLE_BYTE) begin
                            n_phase = PH_NOISE;
                        end
                    end
                    PH_ADDRESS: begin
                        // Broadcast on either side, or an exact match.
                        if (i_rx_byte == r_own_addr || r_own_addr == BROADCAST ||
                            i_rx_byte == BROADCAST) begin
                            n_phase = PH_SIZE;
                        end else begin
                            n_phase = PH_NOISE;
                        end
                    end
                    PH_SIZE: begin
                        n_bytes_left = 5'(i_rx_byte & SIZE_MASK) + 5'd1;
                        n_tn_ptr     = r_cm_ptr;
                        n_crc        = CRC_INIT;
                        n_phase      = PH_DATA;
                    end
                    PH_DATA: begin
                        n_crc = crc_next;
                        if (ptr_next(r_tn_ptr) == r_rd_ptr) begin
                            // Would overrun unread bytes: drop the packet,
                            // committed bytes stay in place.
                            n_phase = PH_NOISE;
                            n_event = EV_DROP;
                        end else begin
                            ram_we       = 1'b1;
                            n_tn_ptr     = ptr_next(r_tn_ptr);
                            n_bytes_left = r_bytes_left - 5'd1;
                            if (n_bytes_left == 5'd0) begin
                                n_phase = PH_CRC1;
                            end
                        end
                    end
                    PH_CRC1: begin
                        n_crc   = crc_next;
                        n_phase = PH_CRC2;
                    end
                    PH_CRC2: begin
                        // A zero residue over payload and CRC means good.
                        if (crc_next == 16'h0000) begin
                            n_cm_ptr = r_tn_ptr;
                            n_event  = EV_COMMIT;
                        end else begin
                            n_event  = EV_CRC_FAIL;
                        end
                        n_phase = PH_NOISE;
                    end
                    default: begin
                        n_phase = PH_NOISE;
                    end
                endcase
            end
        end

        if (accept) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_NOISE;
            r_bytes_left <= 5'd0;
            r_crc        <= CRC_RESET;
            r_rd_ptr     <= '0;
            r_cm_ptr     <= '0;
            r_tn_ptr     <= '0;
            r_out_valid  <= 1'b0;
            r_rd_valid   <= 1'b0;
            r_event      <= EV_NONE;
        end else begin
            r_phase      <= n_phase;
            r_bytes_left <= n_bytes_left;
            r_crc        <= n_crc;
            r_rd_ptr     <= n_rd_ptr;
            r_cm_ptr     <= n_cm_ptr;
            r_tn_ptr     <= n_tn_ptr;
            r_out_valid  <= n_out_valid;
            r_rd_valid   <= n_rd_valid;
            r_event      <= n_event;
        end
    end

    // Payload store. Tentative writes never touch unread committed slots,
    // so a write and a read in the same cycle never collide.
    apdc_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tn_ptr),
        .i_wdata (i_rx_byte),
        .i_re    (ram_re),
        .i_raddr (r_rd_ptr),
        .o_rdata (ram_rdata)
    );

    // Configuration port. Writes complete in the access phase; the port
    // never inserts wait states.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[3:2] == REG_OWN_ADDR);
    assign prdata    = (paddr[3:2] == REG_OWN_ADDR) ? {24'h000000, r_own_addr} : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_addr <= 8'h00;
        end else if (cfg_write) begin
            r_own_addr <= pwdata[7:0];
        end
    end

    // The RAM output holds until the next accepted pop, which cannot happen
    // while a result is waiting, so it is stable for as long as needed.
    assign o_valid        = r_out_valid;
    assign o_read_valid   = r_rd_valid;
    assign o_read_data    = r_rd_valid ? ram_rdata : 8'h00;
    assign o_packet_event = r_event;

endmodule
`default_nettype wire

### hdl/apdc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apdc_checker: port-level checks for the packet deframer
// Watches the top-level ports and flags result or handshake inconsistencies.
// ----------------------------------------------------------------------------
module apdc_checker import apdc_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic        o_read_valid,
    input wire logic [7:0]  o_read_data,
    input wire logic [1:0]  o_packet_event
);

    // A result with no popped byte carries a zero data field.
    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_read_valid |-> o_read_data == 8'h00)
        else $error("read data nonzero without a popped byte");

    // A pop never reports a packet event.
    a_pop_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_read_valid |-> o_packet_event == EV_NONE)
        else $error("packet event reported together with a popped byte");

    // The block takes a word whenever no result is waiting.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with an empty result stage");

    // Reset empties the result stage.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // A stalled result holds its contents.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_read_valid) &&
            $stable(o_read_data) && $stable(o_packet_event))
        else $error("stalled result changed");

endmodule

bind addressed_packet_deframer_crc apdc_checker u_apdc_checker (.*);
`default_nettype wire

### tb/addressed_packet_deframer_crc_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// addressed_packet_deframer_crc_tb: self-checking bench for the packet deframer
// Drives received bytes and pop requests through the valid/ready input channel.
// A bit-level predictor of the framing, CRC-16/XMODEM check and commit FIFO
// works out every result word, and the bench checks each one. It starts with a
// table of directed words, then runs random packets, pops and noise under
// several device addresses, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module addressed_packet_deframer_crc_tb import apdc_pkg::*;;

    localparam int FIFO_SLOTS   = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_WORDS  = 220;
    localparam int N_ADDR_PLANS = 5;
    localparam int N_DIR        = 36;

    // Where the byte of a word comes from. CRC bytes are filled in from the
    // predictor's running CRC when the word is sent, so a packet in the table
    // can carry a good or a deliberately broken checksum.
    typedef enum logic [1:0] {
        SRC_LIT     = 2'd0,
        SRC_CRC_HI  = 2'd1,
        SRC_CRC_LO  = 2'd2,
        SRC_CRC_BAD = 2'd3
    } t_byte_src;

    typedef struct packed {
        logic       rv;
        logic [7:0] data;
        t_event     ev;
    } t_result;

    typedef struct packed {
        logic      op;
        logic [7:0] b;
        t_byte_src src;
        bit        typed;
        t_result   want;
    } t_stim_row;

    localparam t_result QUIET = '{1'b0, 8'h00, EV_NONE};

    // Directed words. The device address is 0xA5 while this table runs.
    // Rows with typed set carry the result that must come back; the others
    // are checked against the predictor.
    localparam t_stim_row DIR_ROWS [N_DIR] = '{
        // A pop straight after reset finds nothing committed.
        '{OP_POP, 8'h00, SRC_LIT, 1'b1, QUIET},
        // A nonzero byte in the noise phase is ignored.
        '{OP_RX,  8'hFF, SRC_LIT, 1'b1, QUIET},
        // Preamble broken by a byte that is neither zero nor sync.
        '{OP_RX,  8'h00, SRC_LIT, 1'b0, QUIET},
        '{OP_RX,  8'h12, SRC_LIT, 1'b0, QUIET},
        // Two preamble bytes, sync, then an address that does not match.
        '{OP_RX,  8'h00, SRC_LIT, 1'b0, QUIET},
        '{OP_RX,  8'h00, SRC_LIT, 1'b0, QUIET},
        '{OP_RX,  8'h55, SRC_LIT, 1'b0, QUIET},
        '{OP_RX,  8'h11, SRC_LIT, 1'b1, QUIET},
        // Packet to our own address, size byte with the high nibble set and a
        // one-byte payload, good CRC: committed.
        '{OP_RX,  8'h00, SRC_LIT, 1'b0, QUIET},
        '{OP_RX,  8'h55, SRC_LIT, 1'b0, QUIET},
        '{OP_RX,  8'hA5, SRC_LIT, 1'b0, QUIET},
        '{OP_RX,  8'hF0, SRC_LIT, 1'b0, QUIET},
        '{OP_RX,  8'hFF, SRC_LIT, 1'b0, QUIET},
        '{OP_RX,  8'h00, SRC_CRC_HI, 1'b0, QUIET},
        '{OP_RX,  8'h00, SRC_CRC_LO, 1'b1, '{1'b0, 8'h00, EV_COMMIT}},
        // Broadcast address zero, two bytes, corrupted CRC: rejected.
        '{OP_RX,  8'h00, SRC_LIT, 1'b0, QUIET},
        '{OP_RX,  8'h55, SRC_LIT, 1'b0, QUIET},
        '{OP_RX,  8'h00, SRC_LIT, 1'b0, QUIET},
        '{OP_RX,  8'h01, SRC_LIT, 1'b0, QUIET},
        '{OP_RX,  8'h00, SRC_LIT, 1'b0, QUIET},
        '{OP_RX,  8'h7E, SRC_LIT, 1'b0, QUIET},
        '{OP_RX,  8'h00, SRC_CRC_BAD, 1'b0, QUIET},
        '{OP_RX,  8'h00, SRC_CRC_LO, 1'b1, '{1'b0, 8'h00, EV_CRC_FAIL}},
        // Largest size nibble with one byte still committed: the FIFO takes
        // six more bytes and the seventh drops the packet.
        '{OP_RX,  8'h00, SRC_LIT, 1'b0, QUIET},
        '{OP_RX,  8'h55, SRC_LIT, 1'b0, QUIET},
        '{OP_RX,  8'hA5, SRC_LIT, 1'b0, QUIET},
        '{OP_RX,  8'h0F, SRC_LIT, 1'b0, QUIET},
        '{OP_RX,  8'h80, SRC_LIT, 1'b0, QUIET},
        '{OP_RX,  8'h01, SRC_LIT, 1'b0, QUIET},
        '{OP_RX,  8'hFE, SRC_LIT, 1'b0, QUIET},
        '{OP_RX,  8'h7F, SRC_LIT, 1'b0, QUIET},
        '{OP_RX,  8'h00, SRC_LIT, 1'b0, QUIET},
        '{OP_RX,  8'hFF, SRC_LIT, 1'b0, QUIET},
        '{OP_RX,  8'h3C, SRC_LIT, 1'b1, '{1'b0, 8'h00, EV_DROP}},
        // The committed byte survives the drop; the FIFO is empty after it.
        '{OP_POP, 8'h00, SRC_LIT, 1'b1, '{1'b1, 8'hFF, EV_NONE}},
        '{OP_POP, 8'hFF, SRC_LIT, 1'b1, QUIET}
    };

    // ------------------------------------------------------------------------
    // Block signals. Every input is known from time zero.
    // ------------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_op = OP_RX;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_read_valid;
    logic [7:0]  o_read_data;
    logic [1:0]  o_packet_event;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'h0;
    logic [31:0] pwdata = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    addressed_packet_deframer_crc dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_op           (i_op),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_read_valid   (o_read_valid),
        .o_read_data    (o_read_data),
        .o_packet_event (o_packet_event),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor state: the parser, the running CRC and the commit FIFO with
    // its read, committed and tentative pointers, as they stand after reset.
    // ------------------------------------------------------------------------
    logic [7:0]  own_m = 8'h00;
    t_phase      phase_m = PH_NOISE;
    logic [4:0]  left_m = 5'd0;
    logic [15:0] crc_m = CRC_RESET;
    logic [7:0]  fifo_m [FIFO_SLOTS] = '{default: 8'h00};
    int          rd_m = 0;
    int          cm_m = 0;
    int          tp_m = 0;

    // CRC value whose high byte went out last; its low byte follows it.
    logic [15:0] sent_crc = 16'h0000;

    // Expected result words, oldest first.
    t_result     pending_results [$];

    int errors = 0;
    int cycle_count = 0;
    int words_sent = 0;
    int words_checked = 0;
    int commits = 0;
    int crc_fails = 0;
    int drops = 0;
    int bytes_popped = 0;
    int empty_pops = 0;
    int addr_settings = 0;

    // Idle patterns. While a side is calm it never idles; otherwise most gaps
    // are short and a few are long.
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;
    int rx_stall = 0;
    int rx_gap = 0;

    // CRC-16/XMODEM, one message bit at a time, MSB first.
    function automatic logic [15:0] crc_xmodem_byte(input logic [15:0] crc,
                                                    input logic [7:0]  d);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int k = 7; k >= 0; k--) begin
            fb = c[15] ^ d[k];
            c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    // Advances the predictor by one accepted word and returns its result.
    function automatic t_result deframe_word(input logic op, input logic [7:0] b);
        t_result r;
        int      nxt;
        r = QUIET;
        if (op == OP_RX) begin
            case (phase_m)
                PH_NOISE: begin
                    if (b == PREAMBLE_BYTE) phase_m = PH_PREAMBLE;
                end
                PH_PREAMBLE: begin
                    if (b != PREAMBLE_BYTE) begin
                        phase_m = (b == SYNC_BYTE) ? PH_ADDRESS : PH_NOISE;
                    end
                end
                PH_ADDRESS: begin
                    // Zero on either side acts as a broadcast.
                    if (b == own_m || own_m == BROADCAST || b == BROADCAST) begin
                        phase_m = PH_SIZE;
                    end else begin
                        phase_m = PH_NOISE;
                    end
                end
                PH_SIZE: begin
                    // A new packet always overwrites any abandoned tentative bytes.
                    left_m  = {1'b0, b[3:0] & SIZE_MASK[3:0]} + 5'd1;
                    tp_m    = cm_m;
                    crc_m   = CRC_INIT;
                    phase_m = PH_DATA;
                end
                PH_DATA: begin
                    crc_m = crc_xmodem_byte(crc_m, b);
                    nxt   = (tp_m + 1) % FIFO_SLOTS;
                    if (nxt == rd_m) begin
                        // One slot always stays free, so the FIFO is full here.
                        phase_m = PH_NOISE;
                        r.ev    = EV_DROP;
                        drops++;
                    end else begin
                        fifo_m[tp_m] = b;
                        tp_m   = nxt;
                        left_m = left_m - 5'd1;
                        if (left_m == 5'd0) phase_m = PH_CRC1;
                    end
                end
                PH_CRC1: begin
                    crc_m   = crc_xmodem_byte(crc_m, b);
                    phase_m = PH_CRC2;
                end
                PH_CRC2: begin
                    if (crc_xmodem_byte(crc_m, b) == 16'h0000) begin
                        cm_m = tp_m;
                        r.ev = EV_COMMIT;
                        commits++;
                    end else begin
                        r.ev = EV_CRC_FAIL;
                        crc_fails++;
                    end
                    phase_m = PH_NOISE;
                end
                default: phase_m = PH_NOISE;
            endcase
        end else if (rd_m != cm_m) begin
            r.rv   = 1'b1;
            r.data = fifo_m[rd_m];
            rd_m   = (rd_m + 1) % FIFO_SLOTS;
            bytes_popped++;
        end else begin
            empty_pops++;
        end
        return r;
    endfunction

    function automatic int pick_gap(input bit calm);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    task automatic report(input string msg);
        errors++;
        if (errors <= 30) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Offers one word on the input channel and waits until it is taken; the
    // predicted result of the word comes back once the handshake is done.
    // Called at a clock edge, and it returns at the edge that accepted it.
    task automatic push_word(input logic op, input logic [7:0] lit,
                             input t_byte_src src, output t_result r);
        logic [7:0] b;
        int         gap;
        case (src)
            SRC_CRC_HI: begin
                sent_crc = crc_m;
                b = crc_m[15:8];
            end
            SRC_CRC_BAD: begin
                sent_crc = crc_m;
                b = crc_m[15:8] ^ 8'h01;
            end
            SRC_CRC_LO: b = sent_crc[7:0];
            default:    b = lit;
        endcase
        gap = pick_gap(tx_calm);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_op      <= op;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_ready !== 1'b1) @(posedge i_clk);
        r = deframe_word(op, b);
        words_sent++;
    endtask

    task automatic feed(input logic op, input logic [7:0] lit, input t_byte_src src);
        t_result r;
        push_word(op, lit, src, r);
        pending_results.push_back(r);
    endtask

    // Lowers valid and waits until every expected result word has been taken.
    // Every word gives one result, so a short pause covers the pipeline.
    task automatic settle_idle();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access until pready completes it.
    task automatic write_own_address(input logic [7:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_OWN_ADDR, 2'b00};
        pwdata  <= {24'h0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        own_m = v;
        addr_settings++;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One well-formed packet with random content. Most packets are short so
    // the FIFO keeps turning over; longer ones push it into overflow.
    // A pop is slipped in among the payload and CRC bytes now and then.
    task automatic send_packet();
        int         n_pre;
        int         roll;
        logic [3:0] nib;
        logic [7:0] addr;
        n_pre = $urandom_range(1, 3);
        for (int k = 0; k < n_pre; k++) feed(OP_RX, PREAMBLE_BYTE, SRC_LIT);
        feed(OP_RX, SYNC_BYTE, SRC_LIT);
        roll = $urandom_range(0, 99);
        if (roll < 70 && own_m != BROADCAST) addr = own_m;
        else if (roll < 85) addr = BROADCAST;
        else addr = 8'($urandom_range(0, 255));
        feed(OP_RX, addr, SRC_LIT);
        nib = ($urandom_range(0, 99) < 80) ? 4'($urandom_range(0, 3))
                                           : 4'($urandom_range(4, 15));
        feed(OP_RX, {4'($urandom_range(0, 15)), nib}, SRC_LIT);
        for (int k = 0; k <= int'(nib); k++) begin
            if ($urandom_range(0, 9) == 0) feed(OP_POP, 8'($urandom_range(0, 255)), SRC_LIT);
            feed(OP_RX, 8'($urandom_range(0, 255)), SRC_LIT);
        end
        feed(OP_RX, 8'h00, ($urandom_range(0, 99) < 88) ? SRC_CRC_HI : SRC_CRC_BAD);
        if ($urandom_range(0, 9) == 0) feed(OP_POP, 8'($urandom_range(0, 255)), SRC_LIT);
        feed(OP_RX, 8'h00, SRC_CRC_LO);
    endtask

    // One random stretch of stimulus: a packet, a burst of pops, line noise
    // or a packet that breaks off part way through.
    task automatic play_sequence();
        int roll;
        int n;
        if ($urandom_range(0, 11) == 0) tx_calm = !tx_calm;
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
            send_packet();
        end else if (roll < 82) begin
            n = $urandom_range(1, 8);
            for (int k = 0; k < n; k++) feed(OP_POP, 8'($urandom_range(0, 255)), SRC_LIT);
        end else if (roll < 92) begin
            n = $urandom_range(1, 5);
            for (int k = 0; k < n; k++) feed(OP_RX, 8'($urandom_range(0, 255)), SRC_LIT);
        end else begin
            // Cut short before the payload ends; the parser eats whatever follows.
            feed(OP_RX, PREAMBLE_BYTE, SRC_LIT);
            feed(OP_RX, SYNC_BYTE, SRC_LIT);
            feed(OP_RX, BROADCAST, SRC_LIT);
            n = $urandom_range(0, 15);
            feed(OP_RX, 8'(n), SRC_LIT);
            n = $urandom_range(0, n);
            for (int k = 0; k < n; k++) feed(OP_RX, 8'($urandom_range(0, 255)), SRC_LIT);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: check each word taken against the oldest expectation, then
    // decide whether to stall the next cycle.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid === 1'b1 && i_ready === 1'b1) begin
                if (pending_results.size() == 0) begin
                    report($sformatf("result word with nothing expected (rv %b data %h ev %0d)",
                                     o_read_valid, o_read_data, o_packet_event));
                end else begin
                    if (o_read_valid !== pending_results[0].rv) begin
                        report($sformatf("word %0d read_valid %b, expected %b", words_checked,
                                         o_read_valid, pending_results[0].rv));
                    end
                    if (o_read_data !== pending_results[0].data) begin
                        report($sformatf("word %0d read_data %h, expected %h", words_checked,
                                         o_read_data, pending_results[0].data));
                    end
                    if (o_packet_event !== pending_results[0].ev) begin
                        report($sformatf("word %0d packet_event %0d, expected %s", words_checked,
                                         o_packet_event, pending_results[0].ev.name()));
                    end
                    void'(pending_results.pop_front());
                    words_checked++;
                end
            end
            if ($urandom_range(0, 199) == 0) rx_calm = !rx_calm;
            if (rx_stall > 0) begin
                rx_stall--;
                i_ready <= 1'b0;
            end else begin
                rx_gap = pick_gap(rx_calm);
                if (rx_gap > 0) begin
                    rx_stall = rx_gap - 1;
                    i_ready <= 1'b0;
                end else begin
                    i_ready <= 1'b1;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed table, then random phases under a range
    // of device addresses, both extremes among them.
    // ------------------------------------------------------------------------
    initial begin
        t_result    r;
        logic [7:0] own_plan [N_ADDR_PLANS];
        int         phase_start;
        own_plan[0] = 8'hFF;
        own_plan[1] = 8'h00;
        own_plan[2] = 8'($urandom_range(1, 254));
        own_plan[3] = 8'h01;
        own_plan[4] = 8'($urandom_range(1, 254));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_own_address(8'hA5);
        for (int n = 0; n < N_DIR; n++) begin
            push_word(DIR_ROWS[n].op, DIR_ROWS[n].b, DIR_ROWS[n].src, r);
            pending_results.push_back(DIR_ROWS[n].typed ? DIR_ROWS[n].want : r);
        end

        for (int p = 0; p < N_ADDR_PLANS; p++) begin
            settle_idle();
            write_own_address(own_plan[p]);
            phase_start = words_sent;
            while (words_sent < phase_start + PHASE_WORDS) play_sequence();
        end

        settle_idle();
        $display("Run: %0d words under %0d device addresses, %0d results checked.",
                 words_sent, addr_settings, words_checked);
        $display("Packets: %0d committed, %0d bad CRC, %0d dropped; pops: %0d bytes, %0d empty.",
                 commits, crc_fails, drops, bytes_popped, empty_pops);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/apdc_pkg.sv
hdl/apdc_ram.sv
hdl/addressed_packet_deframer_crc.sv
hdl/apdc_checker.sv
tb/addressed_packet_deframer_crc_tb.sv
